[sv/round_robin_message_scheduler_top_assert.svh]
// Assertion macros for the round-robin message scheduler top level.
`ifndef ROUND_ROBIN_MESSAGE_SCHEDULER_TOP_ASSERT_SVH
`define ROUND_ROBIN_MESSAGE_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RRMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RRMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rrms_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
package rrms_pkg;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF     = 128;
    localparam int MAX_PAYLOAD_DEF = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGHEST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DESC_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DESC     = 3'd4;

    // Function codes
    localparam logic [1:0] FUNC_RECV = 2'd0;
    localparam logic [1:0] FUNC_POST = 2'd1;
    localparam logic [1:0] FUNC_SEND = 2'd2;
    localparam logic [1:0] FUNC_SIZE = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_ACCEPT = 3'd0;
    localparam logic [2:0] KIND_REJECT = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_DESC   = 3'd3;
    localparam logic [2:0] KIND_NONE   = 3'd4;

    // Receive number that requests mark all: entries 1 .. n - 2 before the receive
    localparam logic [6:0] NUM_MARK_ALL = 7'h7F;

    // Mark table read address select
    localparam logic RD_IDX = 1'b0;
    localparam logic RD_NUM = 1'b1;

    // Raise level select
    localparam logic [1:0] LVL_MARKALL = 2'd0;
    localparam logic [1:0] LVL_RECV    = 2'd1;
    localparam logic [1:0] LVL_POST    = 2'd2;

    // Mark write data select
    localparam logic [1:0] WR_RAISE = 2'd0;
    localparam logic [1:0] WR_DESC  = 2'd1;
    localparam logic [1:0] WR_CLEAR = 2'd2;

    // Index counter operations
    localparam logic [1:0] IDX_HOLD = 2'd0;
    localparam logic [1:0] IDX_ONE  = 2'd1;
    localparam logic [1:0] IDX_PTR  = 2'd2;
    localparam logic [1:0] IDX_STEP = 2'd3;

    // Scan counter operations
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_INC  = 2'd2;

    // Result number select
    localparam logic [1:0] RNUM_EFF  = 2'd0;
    localparam logic [1:0] RNUM_SCAN = 2'd1;
    localparam logic [1:0] RNUM_ZERO = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       rd_sel;
        logic       mark_we;
        logic [1:0] wr_sel;
        logic [1:0] lvl_sel;
        logic       size_we;
        logic [1:0] idx_op;
        logic [1:0] cnt_op;
        logic       ptr_wrap;
        logic       ptr_take;
        logic       claim;
        logic       free_buf;
        logic       set_pend;
        logic       clr_pend;
        logic       emit;
        logic [2:0] res_kind;
        logic [1:0] res_num_sel;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       markall;
        logic       in_range;
        logic       size_ok;
        logic       pending;
        logic       reject;
        logic       mark_nz;
        logic       desc_hit;
        logic       idx_last;
        logic       cnt_done;
    } dp_stat_t;

endpackage

[sv/rrms_dp.sv]
// Datapath: registers, mark and size tables, buffer owner, scan pointer, result.
module rrms_dp #(
    parameter int ENTRIES     = rrms_pkg::ENTRIES_DEF,
    parameter int MAX_PAYLOAD = rrms_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rrms_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rrms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]                     func,
    input  logic [6:0]                     message_number,
    input  logic                           description_flag,
    input  logic [7:0]                     payload_length,
    input  logic [7:0]                     priority_req,
    input  logic [6:0]                     entry_size,
    input  rrms_pkg::dp_cmd_t              cmd,
    output rrms_pkg::dp_stat_t             stat,
    output logic                           done,
    output logic [2:0]                     kind,
    output logic [6:0]                     message_number_res,
    output logic                           uses_buffer
);
    import rrms_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [7:0] ENT8  = 8'(ENTRIES);
    localparam logic [7:0] MAXP8 = 8'(MAX_PAYLOAD);

    // Configuration registers
    logic [7:0] table_size_reg;
    logic [7:0] level_low_reg;
    logic [7:0] level_highest_reg;
    logic [7:0] level_desc_low_reg;
    logic [7:0] level_desc_reg;

    // Latched item
    logic [1:0] func_reg;
    logic [6:0] num_reg;
    logic       desc_reg;
    logic [7:0] plen_reg;
    logic [7:0] prio_reg;
    logic [6:0] esize_reg;

    // Control state
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] owner_reg;
    logic          buf_busy_reg;
    logic          pending_reg;

    // Tables
    logic [7:0]         mark_mem [ENTRIES];
    logic [ENTRIES-1:0] mark_vld_reg;
    logic [7:0]         mark_raw_q;
    logic               mark_vld_q;
    logic [IW-1:0]      rd_addr_q;
    logic [6:0]         size_mem [ENTRIES];
    logic [ENTRIES-1:0] size_vld_reg;
    logic [6:0]         size_raw_q;
    logic               size_vld_q;

    // Result registers
    logic       done_reg;
    logic [2:0] kind_reg;
    logic [6:0] num_res_reg;
    logic       uses_reg;

    // Derived values
    logic [7:0]    n_eff;
    logic [7:0]    n_m1;
    logic          in_range;
    logic [6:0]    num_eff;
    logic [7:0]    plen_eff;
    logic [IW-1:0] num_idx;
    logic [IW-1:0] ptr_w;
    logic [IW-1:0] rd_addr;
    logic [7:0]    mark_rdata;
    logic [6:0]    size_rdata;
    logic [7:0]    lvl;
    logic [7:0]    mark_wdata;
    logic          owns;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg     <= 8'd128;
            level_low_reg      <= 8'd1;
            level_highest_reg  <= 8'd2;
            level_desc_low_reg <= 8'd3;
            level_desc_reg     <= 8'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TABLE_SIZE:     table_size_reg     <= cfg_wdata;
                REG_LEVEL_LOW:      level_low_reg      <= cfg_wdata;
                REG_LEVEL_HIGHEST:  level_highest_reg  <= cfg_wdata;
                REG_LEVEL_DESC_LOW: level_desc_low_reg <= cfg_wdata;
                REG_LEVEL_DESC:     level_desc_reg     <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Item capture on start transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg  <= func;
            num_reg   <= message_number;
            desc_reg  <= description_flag;
            plen_reg  <= payload_length;
            prio_reg  <= priority_req;
            esize_reg <= entry_size;
        end
    end

    // Effective table size and clamped number
    always_comb
    begin
        if (table_size_reg == 8'd0)
            n_eff = 8'd1;
        else if (table_size_reg > ENT8)
            n_eff = ENT8;
        else
            n_eff = table_size_reg;
        n_m1     = n_eff - 8'd1;
        in_range = {1'b0, num_reg} < n_eff;
        num_eff  = in_range ? num_reg : n_m1[6:0];
        plen_eff = in_range ? plen_reg : 8'd0;
        num_idx  = num_eff[IW-1:0];
        ptr_w    = (8'(ptr_reg) >= n_eff) ? '0 : ptr_reg;
        rd_addr  = (cmd.rd_sel == RD_NUM) ? num_idx : idx_reg;
    end

    // Mark table: one write at the last read address, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mark_we)
            mark_mem[rd_addr_q] <= mark_wdata;
        mark_raw_q <= mark_mem[rd_addr];
        mark_vld_q <= mark_vld_reg[rd_addr];
        rd_addr_q  <= rd_addr;
    end

    // Size table: written on size load, read at the clamped number
    always_ff @(posedge clk)
    begin
        if (cmd.size_we)
            size_mem[num_reg[IW-1:0]] <= esize_reg;
        size_raw_q <= size_mem[num_idx];
        size_vld_q <= size_vld_reg[num_idx];
    end

    // Entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_vld_reg <= '0;
            size_vld_reg <= '0;
        end
        else
        begin
            if (cmd.mark_we)
                mark_vld_reg[rd_addr_q] <= 1'b1;
            if (cmd.size_we)
                size_vld_reg[num_reg[IW-1:0]] <= 1'b1;
        end
    end

    assign mark_rdata = mark_vld_q ? mark_raw_q : 8'd0;
    assign size_rdata = size_vld_q ? size_raw_q : 7'd0;
    assign owns       = buf_busy_reg && (owner_reg == rd_addr_q);

    // Mark write data
    always_comb
    begin
        case (cmd.lvl_sel)
            LVL_MARKALL: lvl = desc_reg ? level_desc_low_reg : level_low_reg;
            LVL_RECV:    lvl = desc_reg ? level_desc_reg : level_highest_reg;
            LVL_POST:    lvl = prio_reg;
            default:     lvl = 8'd0;
        endcase
        case (cmd.wr_sel)
            WR_RAISE: mark_wdata = (mark_rdata < lvl) ? lvl : mark_rdata;
            WR_DESC:  mark_wdata = owns ? level_highest_reg : level_low_reg;
            WR_CLEAR: mark_wdata = 8'd0;
            default:  mark_wdata = mark_rdata;
        endcase
    end

    // Index step wraps at the table size
    assign idx_next = (8'(idx_reg) == n_m1) ? '0 : idx_reg + IW'(1);

    // Counters, pointer, buffer and pending flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            buf_busy_reg <= 1'b0;
            pending_reg  <= 1'b1;
        end
        else
        begin
            case (cmd.idx_op)
                IDX_ONE:  idx_reg <= IW'(1);
                IDX_PTR:  idx_reg <= ptr_w;
                IDX_STEP: idx_reg <= idx_next;
                default:  ;
            endcase
            case (cmd.cnt_op)
                CNT_ONE: cnt_reg <= CW'(1);
                CNT_INC: cnt_reg <= cnt_reg + CW'(1);
                default: ;
            endcase
            if (cmd.ptr_wrap)
                ptr_reg <= ptr_w;
            else if (cmd.ptr_take)
                ptr_reg <= rd_addr_q;
            if (cmd.claim && plen_eff != 8'd0)
                buf_busy_reg <= 1'b1;
            else if (cmd.free_buf && owns)
                buf_busy_reg <= 1'b0;
            if (cmd.set_pend)
                pending_reg <= 1'b1;
            else if (cmd.clr_pend)
                pending_reg <= 1'b0;
        end
    end

    // Buffer owner, meaningful only while the buffer is busy
    always_ff @(posedge clk)
    begin
        if (cmd.claim && plen_eff != 8'd0)
            owner_reg <= num_idx;
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg <= cmd.res_kind;
            uses_reg <= (cmd.res_kind == KIND_DATA) && owns;
            case (cmd.res_num_sel)
                RNUM_EFF:  num_res_reg <= num_eff;
                RNUM_SCAN: num_res_reg <= 7'(rd_addr_q);
                default:   num_res_reg <= 7'd0;
            endcase
        end
    end

    // Status to controller
    always_comb
    begin
        stat.func     = func_reg;
        stat.markall  = (num_reg == NUM_MARK_ALL) && (n_eff >= 8'd3);
        stat.in_range = in_range;
        stat.size_ok  = {1'b0, num_reg} < ENT8;
        stat.pending  = pending_reg;
        stat.reject   = (plen_eff != 8'd0) &&
                        (buf_busy_reg || plen_eff != {1'b0, size_rdata} || plen_eff > MAXP8);
        stat.mark_nz  = mark_rdata != 8'd0;
        stat.desc_hit = mark_rdata >= level_desc_low_reg;
        stat.idx_last = 8'(idx_reg) == n_m1;
        stat.cnt_done = cnt_reg == n_eff[CW-1:0];
    end

    assign done               = done_reg;
    assign kind               = kind_reg;
    assign message_number_res = num_res_reg;
    assign uses_buffer        = uses_reg;

endmodule

[sv/rrms_ctrl.sv]
// Controller state machine: sequences table walks, scans and read-modify-writes.
module rrms_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rrms_pkg::dp_stat_t stat,
    output rrms_pkg::dp_cmd_t  cmd
);
    import rrms_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_WALK_START = 4'd2;
    localparam logic [3:0] S_WALK       = 4'd3;
    localparam logic [3:0] S_RECV_CHK   = 4'd4;
    localparam logic [3:0] S_RECV_WR    = 4'd5;
    localparam logic [3:0] S_POST_WR    = 4'd6;
    localparam logic [3:0] S_SCAN_START = 4'd7;
    localparam logic [3:0] S_SCAN       = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = RD_IDX;
        cmd.wr_sel      = WR_RAISE;
        cmd.lvl_sel     = LVL_POST;
        cmd.idx_op      = IDX_HOLD;
        cmd.cnt_op      = CNT_HOLD;
        cmd.res_kind    = KIND_NONE;
        cmd.res_num_sel = RNUM_ZERO;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (stat.func)
                    FUNC_RECV:
                    begin
                        if (stat.markall)
                        begin
                            cmd.idx_op   = IDX_ONE;
                            cmd.set_pend = 1'b1;
                            state_next   = S_WALK_START;
                        end
                        else
                            state_next = S_RECV_CHK;
                    end
                    FUNC_POST:
                    begin
                        cmd.rd_sel = RD_NUM;
                        state_next = stat.in_range ? S_POST_WR : S_IDLE;
                    end
                    FUNC_SEND:
                    begin
                        if (!stat.pending)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_wrap = 1'b1;
                            cmd.idx_op   = IDX_PTR;
                            state_next   = S_SCAN_START;
                        end
                    end
                    FUNC_SIZE:
                    begin
                        cmd.size_we = stat.size_ok;
                        state_next  = S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            // Mark-all walk: write entry k while reading entry k+1
            S_WALK_START:
            begin
                cmd.idx_op = IDX_STEP;
                state_next = S_WALK;
            end

            S_WALK:
            begin
                cmd.mark_we = 1'b1;
                cmd.lvl_sel = LVL_MARKALL;
                if (!stat.idx_last)
                    cmd.idx_op = IDX_STEP;
                else
                    state_next = S_RECV_CHK;
            end

            S_RECV_CHK:
            begin
                cmd.res_num_sel = RNUM_EFF;
                if (stat.reject)
                begin
                    cmd.emit     = 1'b1;
                    cmd.res_kind = KIND_REJECT;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.claim  = 1'b1;
                    cmd.rd_sel = RD_NUM;
                    state_next = S_RECV_WR;
                end
            end

            S_RECV_WR:
            begin
                cmd.mark_we     = 1'b1;
                cmd.lvl_sel     = LVL_RECV;
                cmd.set_pend    = 1'b1;
                cmd.emit        = 1'b1;
                cmd.res_kind    = KIND_ACCEPT;
                cmd.res_num_sel = RNUM_EFF;
                state_next      = S_IDLE;
            end

            S_POST_WR:
            begin
                cmd.mark_we  = 1'b1;
                cmd.lvl_sel  = LVL_POST;
                cmd.set_pend = 1'b1;
                state_next   = S_IDLE;
            end

            S_SCAN_START:
            begin
                cmd.idx_op = IDX_STEP;
                cmd.cnt_op = CNT_ONE;
                state_next = S_SCAN;
            end

            // Check last read entry, issue the next read meanwhile
            S_SCAN:
            begin
                if (stat.mark_nz)
                begin
                    cmd.mark_we     = 1'b1;
                    cmd.wr_sel      = stat.desc_hit ? WR_DESC : WR_CLEAR;
                    cmd.free_buf    = !stat.desc_hit;
                    cmd.ptr_take    = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.res_kind    = stat.desc_hit ? KIND_DESC : KIND_DATA;
                    cmd.res_num_sel = RNUM_SCAN;
                    state_next      = S_IDLE;
                end
                else if (stat.cnt_done)
                begin
                    cmd.clr_pend = 1'b1;
                    cmd.emit     = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_STEP;
                    cmd.cnt_op = CNT_INC;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign busy = state_reg != S_IDLE;

endmodule

[sv/round_robin_message_scheduler_top.sv]
// Top level of the round-robin message scheduler.
//
//   Channel   Signals                                           Direction
//   config    cfg_we, cfg_addr, cfg_wdata                       in
//   command   start, busy, func .. entry_size                   in (busy out)
//   result    done, kind, message_number_res, uses_buffer       out
//
// A command transfers when start is high and busy is low; done marks a result
// for one cycle. A mark-all receive walks entries 1 .. n - 2, and a send next
// scans up to n entries from the pointer (n = effective table size).
// Both are paced by the single read port of the mark table: one entry a cycle.
// rst_n clears tables through valid bits at once: no clearing pass.
// Results cannot be stalled; the receiver takes each on its done cycle.
`include "round_robin_message_scheduler_top_assert.svh"

module round_robin_message_scheduler_top #(
    parameter int ENTRIES     = rrms_pkg::ENTRIES_DEF,
    parameter int MAX_PAYLOAD = rrms_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rrms_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rrms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      func,
    input  logic [6:0]                      message_number,
    input  logic                            description_flag,
    input  logic [7:0]                      payload_length,
    input  logic [7:0]                      priority_req,
    input  logic [6:0]                      entry_size,
    output logic                            done,
    output logic [2:0]                      kind,
    output logic [6:0]                      message_number_res,
    output logic                            uses_buffer
);
    import rrms_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    rrms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Tables and registers
    rrms_dp #(
        .ENTRIES     (ENTRIES),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .func               (func),
        .message_number     (message_number),
        .description_flag   (description_flag),
        .payload_length     (payload_length),
        .priority_req       (priority_req),
        .entry_size         (entry_size),
        .cmd                (cmd),
        .stat               (stat),
        .done               (done),
        .kind               (kind),
        .message_number_res (message_number_res),
        .uses_buffer        (uses_buffer)
    );

    // Checks
    `RRMS_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "command not taken")
    `RRMS_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "back-to-back results")
    `RRMS_ASSERT_NOW(a_buf_data, clk, rst_n, done && uses_buffer, kind == KIND_DATA, "buffer on non-data result")
    `RRMS_ASSERT_NOW(a_idle_nowr, clk, rst_n, cmd.mark_we || cmd.size_we, busy, "table write while idle")

endmodule

[verif/round_robin_message_scheduler_top_test.sv]
// Self-checking testbench for the round-robin message scheduler top level.
module round_robin_message_scheduler_top_test;
    import rrms_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;
    localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;
    localparam logic [7:0] NO_HOLDER = 8'hFF;
    // Run limit in time units: far beyond the slowest correct run
    localparam longint RUN_LIMIT = 64'd12_000_000;

    // One command as presented on the input ports
    typedef struct {
        logic [1:0] func;
        logic [6:0] num;
        logic       desc;
        logic [7:0] plen;
        logic [7:0] prio;
        logic [6:0] esize;
    } sched_cmd_t;

    // One result as seen on the output ports
    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] num;
        logic       ub;
    } sched_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  start;
    logic                  busy;
    logic [1:0]            func;
    logic [6:0]            message_number;
    logic                  description_flag;
    logic [7:0]            payload_length;
    logic [7:0]            priority_req;
    logic [6:0]            entry_size;
    logic                  done;
    logic [2:0]            kind;
    logic [6:0]            message_number_res;
    logic                  uses_buffer;

    // Scheduler state as the testbench predicts it
    logic [7:0]  marks [ENTRIES];
    logic [6:0]  sizes [ENTRIES];
    int unsigned rr_ptr;
    bit          buf_held;
    logic [7:0]  buf_holder;
    bit          work_flag;
    logic [7:0]  reg_tsize;
    logic [7:0]  reg_lvl_low;
    logic [7:0]  reg_lvl_high;
    logic [7:0]  reg_lvl_dlo;
    logic [7:0]  reg_lvl_desc;

    sched_res_t due_results [$];
    int         errors = 0;
    bit         calm = 1'b0;

    round_robin_message_scheduler_top i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .start              (start),
        .busy               (busy),
        .func               (func),
        .message_number     (message_number),
        .description_flag   (description_flag),
        .payload_length     (payload_length),
        .priority_req       (priority_req),
        .entry_size         (entry_size),
        .done               (done),
        .kind               (kind),
        .message_number_res (message_number_res),
        .uses_buffer        (uses_buffer)
    );

    always #6 clk = ~clk;

    // Run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("round_robin_message_scheduler_top_test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic void reset_state();
        reg_tsize    = 8'd128;
        reg_lvl_low  = 8'd1;
        reg_lvl_high = 8'd2;
        reg_lvl_dlo  = 8'd3;
        reg_lvl_desc = 8'd4;
        foreach (marks[i])
        begin
            marks[i] = '0;
            sizes[i] = '0;
        end
        rr_ptr     = 0;
        buf_held   = 1'b0;
        buf_holder = NO_HOLDER;
        work_flag  = 1'b1;
    endfunction

    // Table size as the block uses it: zero acts as one, clipped to the table
    function automatic int unsigned live_entries();
        if (reg_tsize == 0)
            return 1;
        if (reg_tsize > ENTRIES)
            return ENTRIES;
        return 32'(reg_tsize);
    endfunction

    function automatic void raise_mark(input int unsigned idx, input logic [7:0] lvl);
        if (idx < ENTRIES && marks[idx] < lvl)
            marks[idx] = lvl;
        work_flag = 1'b1;
    endfunction

    // Advances the predicted state by one command; returns 1 when it yields a result
    function automatic bit schedule_step(input sched_cmd_t c, output sched_res_t r);
        int unsigned n;
        int unsigned num;
        int unsigned plen;
        int unsigned i;
        bit          found;
        bit          owns;
        bit          emits;
        n = live_entries();
        num = 32'(c.num);
        plen = 32'(c.plen);
        r.kind = KIND_NONE;
        r.num = '0;
        r.ub = 1'b0;
        emits = 1'b1;
        case (c.func)
            FUNC_RECV:
            begin
                // Mark all walks entries 1 .. n-2 before the receive itself
                if (c.num == NUM_MARK_ALL)
                    for (i = 1; i + 1 < n; i++)
                        raise_mark(i, c.desc ? reg_lvl_dlo : reg_lvl_low);
                // Out of range: clamp to the last entry and drop the payload
                if (num >= n)
                begin
                    num = n - 1;
                    plen = 0;
                end
                r.num = num[6:0];
                if (plen > 0 && (buf_held || plen != sizes[num] || plen > MAX_PAYLOAD))
                    r.kind = KIND_REJECT;
                else
                begin
                    if (plen > 0)
                    begin
                        buf_held = 1'b1;
                        buf_holder = num[7:0];
                    end
                    raise_mark(num, c.desc ? reg_lvl_desc : reg_lvl_high);
                    r.kind = KIND_ACCEPT;
                end
            end
            FUNC_POST:
            begin
                if (num < n)
                    raise_mark(num, c.prio);
                emits = 1'b0;
            end
            FUNC_SIZE:
            begin
                sizes[num] = c.esize;
                emits = 1'b0;
            end
            default:
            begin
                if (work_flag)
                begin
                    // Round-robin scan; the pointer stays on the entry picked
                    found = 1'b0;
                    for (i = 0; i < n && !found; i++)
                    begin
                        if (rr_ptr >= n)
                            rr_ptr = 0;
                        if (marks[rr_ptr] != 0)
                            found = 1'b1;
                        else
                            rr_ptr++;
                    end
                    if (rr_ptr >= n)
                        rr_ptr = 0;
                    if (!found)
                        work_flag = 1'b0;
                    else
                    begin
                        owns = buf_held && buf_holder == rr_ptr;
                        r.num = rr_ptr[6:0];
                        if (marks[rr_ptr] >= reg_lvl_dlo)
                        begin
                            marks[rr_ptr] = owns ? reg_lvl_high : reg_lvl_low;
                            r.kind = KIND_DESC;
                        end
                        else
                        begin
                            marks[rr_ptr] = '0;
                            if (owns)
                            begin
                                buf_held = 1'b0;
                                buf_holder = NO_HOLDER;
                            end
                            r.kind = KIND_DATA;
                            r.ub = owns;
                        end
                        work_flag = 1'b1;
                    end
                end
            end
        endcase
        return emits;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        sched_res_t want;
        sched_res_t got;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            got = {kind, message_number_res, uses_buffer};
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d number %0d buffer %0b",
                         $time, got.kind, got.num, got.ub);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                if (want !== got)
                begin
                    $display("%0t: expected kind %0d number %0d buffer %0b, got %0d %0d %0b",
                             $time, want.kind, want.num, want.ub, got.kind, got.num, got.ub);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared drivers
    // ---------------------------------------------------------------

    function automatic sched_cmd_t make_cmd(input logic [1:0] f, input logic [6:0] num,
                                            input logic desc, input logic [7:0] plen,
                                            input logic [7:0] prio, input logic [6:0] esize);
        sched_cmd_t c;
        c.func = f;
        c.num = num;
        c.desc = desc;
        c.plen = plen;
        c.prio = prio;
        c.esize = esize;
        return c;
    endfunction

    // Presents one command and holds it until the transfer
    task automatic issue(input sched_cmd_t c);
        sched_res_t r;
        if (!calm && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start            <= 1'b1;
        func             <= c.func;
        message_number   <= c.num;
        description_flag <= c.desc;
        payload_length   <= c.plen;
        priority_req     <= c.prio;
        entry_size       <= c.esize;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (schedule_step(c, r))
            due_results.push_back(r);
    endtask

    // Waits until every result is in and any silent command has finished
    task automatic settle();
        start <= 1'b0;
        while (due_results.size() != 0 || busy === 1'b1)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
    endtask

    // Writes all five registers while the block is idle
    task automatic program_regs(input logic [7:0] ts, input logic [7:0] lo,
                                input logic [7:0] hi, input logic [7:0] dlo,
                                input logic [7:0] dsc);
        logic [CFG_IDX_W-1:0] ids [5];
        logic [7:0]           vals [5];
        ids = '{REG_TABLE_SIZE, REG_LEVEL_LOW, REG_LEVEL_HIGHEST,
                REG_LEVEL_DESC_LOW, REG_LEVEL_DESC};
        vals = '{ts, lo, hi, dlo, dsc};
        settle();
        foreach (ids[k])
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= ids[k];
            cfg_wdata <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        reg_tsize    = ts;
        reg_lvl_low  = lo;
        reg_lvl_high = hi;
        reg_lvl_dlo  = dlo;
        reg_lvl_desc = dsc;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Send next on an empty table, then again with nothing pending
    task automatic test_idle_send();
        issue(make_cmd(FUNC_SEND, 7'd0, 1'b0, 8'd0, 8'd0, 7'd0));
        issue(make_cmd(FUNC_SEND, 7'd0, 1'b0, 8'd0, 8'd0, 7'd0));
    endtask

    // Buffer claim, busy buffer, size mismatch and oversized payload
    task automatic test_receive_buffer();
        issue(make_cmd(FUNC_SIZE, 7'd5, 1'b0, 8'd0, 8'd0, 7'd64));
        issue(make_cmd(FUNC_SIZE, 7'd127, 1'b0, 8'd0, 8'd0, 7'd0));
        issue(make_cmd(FUNC_RECV, 7'd5, 1'b0, 8'd64, 8'd0, 7'd0));
        issue(make_cmd(FUNC_RECV, 7'd6, 1'b1, 8'd0, 8'd0, 7'd0));
        issue(make_cmd(FUNC_RECV, 7'd5, 1'b0, 8'd64, 8'd0, 7'd0));
        issue(make_cmd(FUNC_RECV, 7'd7, 1'b0, 8'd3, 8'd0, 7'd0));
        issue(make_cmd(FUNC_RECV, 7'd9, 1'b1, 8'd255, 8'd0, 7'd0));
    endtask

    // Posts only raise a mark
    task automatic test_post_levels();
        issue(make_cmd(FUNC_POST, 7'd9, 1'b0, 8'd0, 8'd255, 7'd0));
        issue(make_cmd(FUNC_POST, 7'd9, 1'b0, 8'd0, 8'd1, 7'd0));
        issue(make_cmd(FUNC_POST, 7'd0, 1'b0, 8'd0, 8'd0, 7'd0));
        issue(make_cmd(FUNC_POST, 7'd127, 1'b0, 8'd0, 8'd128, 7'd0));
    endtask

    // Data with buffer, description then data of the same entry
    task automatic test_send_order();
        repeat (6) issue(make_cmd(FUNC_SEND, 7'd0, 1'b0, 8'd0, 8'd0, 7'd0));
    endtask

    // Mark-all receive with and without the description flag
    task automatic test_mark_all();
        issue(make_cmd(FUNC_RECV, NUM_MARK_ALL, 1'b1, 8'd0, 8'd0, 7'd0));
        repeat (2) issue(make_cmd(FUNC_SEND, 7'd0, 1'b0, 8'd0, 8'd0, 7'd0));
        issue(make_cmd(FUNC_RECV, NUM_MARK_ALL, 1'b0, 8'd0, 8'd0, 7'd0));
    endtask

    // Small, zero and oversized table sizes with extreme levels
    task automatic test_range_clamp();
        program_regs(8'd4, 8'd1, 8'd2, 8'd3, 8'd4);
        issue(make_cmd(FUNC_RECV, 7'd100, 1'b0, 8'd5, 8'd0, 7'd0));
        issue(make_cmd(FUNC_POST, 7'd50, 1'b0, 8'd0, 8'd9, 7'd0));
        issue(make_cmd(FUNC_SIZE, 7'd120, 1'b0, 8'd0, 8'd0, 7'd7));
        repeat (2) issue(make_cmd(FUNC_SEND, 7'd0, 1'b0, 8'd0, 8'd0, 7'd0));
        program_regs(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        issue(make_cmd(FUNC_RECV, NUM_MARK_ALL, 1'b1, 8'd0, 8'd0, 7'd0));
        issue(make_cmd(FUNC_SEND, 7'd0, 1'b0, 8'd0, 8'd0, 7'd0));
        program_regs(8'd200, 8'd1, 8'd1, 8'd1, 8'd1);
        issue(make_cmd(FUNC_RECV, 7'd127, 1'b0, 8'd0, 8'd0, 7'd0));
        issue(make_cmd(FUNC_SEND, 7'd0, 1'b0, 8'd0, 8'd0, 7'd0));
    endtask

    // Mostly well-formed traffic within the table, with some noise
    function automatic sched_cmd_t traffic_cmd();
        sched_cmd_t  c;
        int unsigned n;
        int unsigned pick;
        n = live_entries();
        pick = $urandom_range(0, 99);
        c.func = FUNC_SEND;
        c.num = 7'($urandom_range(0, n - 1));
        c.desc = 1'($urandom_range(0, 1));
        c.plen = 8'($urandom_range(0, 255));
        c.prio = 8'($urandom_range(0, 255));
        c.esize = 7'($urandom_range(0, 64));
        if (pick >= 35 && pick < 65)
        begin
            c.func = FUNC_RECV;
            if ($urandom_range(0, 99) < 4)
                c.num = NUM_MARK_ALL;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: c.plen = 8'd0;
                10, 11, 12, 13, 14, 15, 16: c.plen = {1'b0, sizes[c.num]};
                default: ;
            endcase
        end
        else if (pick >= 65 && pick < 85)
            c.func = FUNC_POST;
        else if (pick >= 85 && pick < 95)
            c.func = FUNC_SIZE;
        else if (pick >= 95)
        begin
            c.func = 2'($urandom_range(0, 3));
            c.num = 7'($urandom_range(0, 127));
        end
        return c;
    endfunction

    task automatic test_random_traffic();
        logic [7:0] ts_pick [8];
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] dlo;
        logic [7:0] dsc;
        ts_pick = '{8'd128, 8'd2, 8'd8, 8'd3, 8'd17, 8'd40, 8'd1, 8'd255};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 2 == 0)
            begin
                // Ordered levels reach every send path
                lo  = 8'($urandom_range(1, 20));
                hi  = lo + 8'($urandom_range(0, 20));
                dlo = hi + 8'($urandom_range(1, 20));
                dsc = dlo + 8'($urandom_range(0, 150));
            end
            else
            begin
                lo  = (ph == 1) ? 8'd255 : 8'($urandom_range(1, 255));
                hi  = (ph == 1) ? 8'd1 : 8'($urandom_range(1, 255));
                dlo = (ph == 5) ? 8'd255 : 8'($urandom_range(1, 255));
                dsc = (ph == 5) ? 8'd1 : 8'($urandom_range(1, 255));
            end
            program_regs(ts_pick[ph], lo, hi, dlo, dsc);
            // One long stretch without gaps
            calm = (ph == 3);
            repeat (62) issue(traffic_cmd());
        end
        calm = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_addr         <= REG_TABLE_SIZE;
        cfg_wdata        <= '0;
        start            <= 1'b0;
        func             <= FUNC_SEND;
        message_number   <= '0;
        description_flag <= 1'b0;
        payload_length   <= '0;
        priority_req     <= '0;
        entry_size       <= '0;
        reset_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_send();
        test_receive_buffer();
        test_post_levels();
        test_send_order();
        test_mark_all();
        test_range_clamp();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("round_robin_message_scheduler_top_test passed");
        else
            $display("round_robin_message_scheduler_top_test failed");
        $finish;
    end

endmodule
